>>> hw/rtl/nnlb_pkg.sv
// Shared constants, word types and sequencer states of the nearest node link builder.
package nnlb_pkg;

	localparam int MAX_NODES     = 64;
	localparam int MAX_ENDPOINTS = 64;
	localparam int COORD_BITS    = 11;
	localparam int MAX_RESULTS   = 32;

	// Fixed widths of the interface fields
	localparam int FIELD_COORD_W = 11;
	localparam int FIELD_NODE_W  = 6;
	localparam int FIELD_LINK_W  = 5;

	localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EP_AW    = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;
	localparam int NODE_CW  = $clog2(MAX_NODES + 1);
	localparam int EP_CW    = $clog2(MAX_ENDPOINTS + 1);
	localparam int LINK_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int NLINK_W  = $clog2(MAX_RESULTS + 1);
	localparam int PT_W     = 2 * COORD_BITS;
	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int DIST_W   = SQ_W + 1;

	localparam logic MODE_NODE     = 1'b0;
	localparam logic MODE_ENDPOINT = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [FIELD_COORD_W-1:0] point_x;
		logic [FIELD_COORD_W-1:0] point_y;
	} cmd_word_t;

	typedef struct packed {
		logic [FIELD_LINK_W-1:0]  link_number;
		logic [FIELD_NODE_W-1:0]  node_first;
		logic [FIELD_NODE_W-1:0]  node_second;
		logic [FIELD_COORD_W-1:0] first_x;
		logic [FIELD_COORD_W-1:0] first_y;
		logic [FIELD_COORD_W-1:0] second_x;
		logic [FIELD_COORD_W-1:0] second_y;
		logic                     no_nodes;
		logic                     last_link;
	} link_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_EP_RD,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

>>> hw/rtl/nearest_node_link_builder.sv
// Nearest node link builder: point tables, nearest node search and link word output.
//
// Each command word appends one point to the node table (mode 0) or to the end point
// table (mode 1); an append to a full table is dropped. After every command the block
// walks the end point pairs (0,1), (2,3), ... up to 32 of them and sends one link word
// per pair, carrying for each end the index of the nearest node by squared Euclidean
// distance, the lower index winning a tie. With no nodes the indices are 0 and no_nodes
// is set; with fewer than two end points no word is sent. One pipelined distance unit
// (subtract, square, add and compare) scans the node memory at one node per cycle, once
// for each end of each link; cmd_stall stays high from the accepted command until the
// block is back in idle, also while a link word is stalled.
module nearest_node_link_builder
	import nnlb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_word_t  cmd,
	output logic       link_valid,
	input  logic       link_stall,
	output link_word_t link
);

	state_t state_q, state_d;

	logic [NODE_CW-1:0] node_cnt_q;
	logic [EP_CW-1:0]   ep_cnt_q;
	logic [NLINK_W-1:0] n_q, n_d;
	logic [LINK_W-1:0]  link_q;
	logic               end_q;
	logic [NODE_CW-1:0] scan_idx_q;
	logic               have_q;
	logic               link_valid_q;

	logic [PT_W-1:0] node_mem [MAX_NODES];
	logic [PT_W-1:0] ep_mem [MAX_ENDPOINTS];

	logic [PT_W-1:0] ep_rd_q;
	logic [PT_W-1:0] first_pt_q;
	logic [NODE_AW-1:0] first_node_q;

	// distance pipeline
	logic               v_s1, v_s2, v_s3;
	logic [PT_W-1:0]    node_rd_s1;
	logic [NODE_AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]    sqx_s3, sqy_s3;
	logic [DIST_W-1:0]  dist_sum;
	logic [DIST_W-1:0]  best_d_q;
	logic [NODE_AW-1:0] best_idx_q;

	logic accept, take, scan_issue, scan_done, last, node_we, ep_we, better;
	logic [PT_W-1:0] cmd_pt;
	logic [EP_CW-1:0] pairs;
	logic [EP_AW-1:0] ep_addr;
	logic [COORD_BITS-1:0] ex, ey, nx, ny;

	assign cmd_pt  = {COORD_BITS'(cmd.point_y), COORD_BITS'(cmd.point_x)};
	assign accept  = cmd_valid && !cmd_stall;
	assign take    = link_valid_q && !link_stall;
	assign node_we = accept && (cmd.mode == MODE_NODE) &&
		(32'(node_cnt_q) < 32'(MAX_NODES));
	assign ep_we   = accept && (cmd.mode == MODE_ENDPOINT) &&
		(32'(ep_cnt_q) < 32'(MAX_ENDPOINTS));
	assign ep_addr = EP_AW'({link_q, end_q});
	assign pairs   = ep_cnt_q >> 1;
	assign last    = (NLINK_W'(link_q) + NLINK_W'(1)) == n_q;
	assign link_valid = link_valid_q;

	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q != node_cnt_q);
	assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !v_s1 && !v_s2 && !v_s3;

	always_comb begin
		if (32'(pairs) > 32'(MAX_RESULTS)) begin
			n_d = NLINK_W'(MAX_RESULTS);
		end else begin
			n_d = NLINK_W'(pairs);
		end
	end

	// next state
	always_comb begin
		state_d   = state_q;
		cmd_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_START;
			end
			ST_START: begin
				if (n_d == '0) state_d = ST_IDLE;
				else state_d = ST_EP_RD;
			end
			ST_EP_RD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done) state_d = end_q ? ST_OUT : ST_EP_RD;
			end
			ST_OUT: begin
				if (take) state_d = last ? ST_IDLE : ST_EP_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_cnt_q   <= '0;
			ep_cnt_q     <= '0;
			n_q          <= '0;
			link_q       <= '0;
			end_q        <= 1'b0;
			scan_idx_q   <= '0;
			have_q       <= 1'b0;
			link_valid_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= scan_issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (node_we) node_cnt_q <= node_cnt_q + NODE_CW'(1);
			if (ep_we) ep_cnt_q <= ep_cnt_q + EP_CW'(1);
			if (state_q == ST_START) begin
				n_q    <= n_d;
				link_q <= '0;
				end_q  <= 1'b0;
			end
			if (state_q == ST_EP_RD) begin
				scan_idx_q <= '0;
				have_q     <= 1'b0;
			end
			if (scan_issue) scan_idx_q <= scan_idx_q + NODE_CW'(1);
			if (v_s3 && better) have_q <= 1'b1;
			if (scan_done) begin
				if (!end_q) end_q <= 1'b1;
				else link_valid_q <= 1'b1;
			end
			if (take) begin
				link_valid_q <= 1'b0;
				link_q       <= link_q + LINK_W'(1);
				end_q        <= 1'b0;
			end
		end
	end

	// point memories
	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_cnt_q[NODE_AW-1:0]] <= cmd_pt;
		if (scan_issue) node_rd_s1 <= node_mem[scan_idx_q[NODE_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ep_we) ep_mem[ep_cnt_q[EP_AW-1:0]] <= cmd_pt;
		if (state_q == ST_EP_RD) ep_rd_q <= ep_mem[ep_addr];
	end

	// distance unit: absolute differences, squares, then sum and compare
	assign ex = ep_rd_q[COORD_BITS-1:0];
	assign ey = ep_rd_q[PT_W-1:COORD_BITS];
	assign nx = node_rd_s1[COORD_BITS-1:0];
	assign ny = node_rd_s1[PT_W-1:COORD_BITS];
	assign dist_sum = DIST_W'(sqx_s3) + DIST_W'(sqy_s3);
	assign better   = !have_q || (dist_sum < best_d_q);

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q[NODE_AW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		dx_s2  <= (ex >= nx) ? ex - nx : nx - ex;
		dy_s2  <= (ey >= ny) ? ey - ny : ny - ey;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		if (state_q == ST_EP_RD) begin
			best_idx_q <= '0;
		end else if (v_s3 && better) begin
			best_idx_q <= idx_s3;
			best_d_q   <= dist_sum;
		end
	end

	// hold first end, then load the link word
	always_ff @(posedge clk) begin
		if (scan_done && !end_q) begin
			first_pt_q   <= ep_rd_q;
			first_node_q <= best_idx_q;
		end
		if (scan_done && end_q) begin
			link.link_number <= FIELD_LINK_W'(link_q);
			link.node_first  <= FIELD_NODE_W'(first_node_q);
			link.node_second <= FIELD_NODE_W'(best_idx_q);
			link.first_x     <= FIELD_COORD_W'(first_pt_q[COORD_BITS-1:0]);
			link.first_y     <= FIELD_COORD_W'(first_pt_q[PT_W-1:COORD_BITS]);
			link.second_x    <= FIELD_COORD_W'(ex);
			link.second_y    <= FIELD_COORD_W'(ey);
			link.no_nodes    <= (node_cnt_q == '0);
			link.last_link   <= last;
		end
	end

endmodule

>>> bench/nearest_node_link_builder_tb.sv
// Testbench for the nearest node link builder: directed and random command words checked against a local table model.
`timescale 1ns / 100ps
module nearest_node_link_builder_tb
	import nnlb_pkg::*;
();

	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int COORD_MAX    = (1 << FIELD_COORD_W) - 1;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cmd_valid  = 1'b0;
	logic       cmd_stall;
	cmd_word_t  cmd        = '0;
	logic       link_valid;
	logic       link_stall = 1'b0;
	link_word_t link;

	int cmd_idle_pct  = 0;
	int link_idle_pct = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	// Local copy of the point tables
	logic [PT_W-1:0] node_pts [MAX_NODES];
	logic [PT_W-1:0] end_pts  [MAX_ENDPOINTS];
	int              node_cnt = 0;
	int              end_cnt  = 0;
	link_word_t      pending_links [$];

	nearest_node_link_builder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.link_valid (link_valid),
		.link_stall (link_stall),
		.link       (link)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [FIELD_NODE_W-1:0] closest_node(input logic [PT_W-1:0] p);
		longint best_d;
		longint d;
		longint dx;
		longint dy;
		int     best;
		best   = 0;
		best_d = -1;
		for (int k = 0; k < node_cnt; k++) begin
			dx = longint'(p[COORD_BITS-1:0]) - longint'(node_pts[k][COORD_BITS-1:0]);
			dy = longint'(p[PT_W-1:COORD_BITS]) - longint'(node_pts[k][PT_W-1:COORD_BITS]);
			d  = dx * dx + dy * dy;
			// strict compare keeps the lower index on a tie
			if (best_d < 0 || d < best_d) begin
				best_d = d;
				best   = k;
			end
		end
		return FIELD_NODE_W'(best);
	endfunction

	function automatic void predict_links(input cmd_word_t w);
		logic [PT_W-1:0] p;
		logic [PT_W-1:0] a;
		logic [PT_W-1:0] b;
		link_word_t      lw;
		int              n_links;
		p = {w.point_y, w.point_x};
		if (w.mode == MODE_NODE) begin
			if (node_cnt < MAX_NODES) begin
				node_pts[node_cnt] = p;
				node_cnt++;
			end
		end else begin
			if (end_cnt < MAX_ENDPOINTS) begin
				end_pts[end_cnt] = p;
				end_cnt++;
			end
		end
		n_links = end_cnt / 2;
		if (n_links > MAX_RESULTS)
			n_links = MAX_RESULTS;
		for (int k = 0; k < n_links; k++) begin
			a              = end_pts[2 * k];
			b              = end_pts[2 * k + 1];
			lw.link_number = FIELD_LINK_W'(k);
			lw.node_first  = closest_node(a);
			lw.node_second = closest_node(b);
			lw.first_x     = a[COORD_BITS-1:0];
			lw.first_y     = a[PT_W-1:COORD_BITS];
			lw.second_x    = b[COORD_BITS-1:0];
			lw.second_y    = b[PT_W-1:COORD_BITS];
			lw.no_nodes    = (node_cnt == 0);
			lw.last_link   = (k + 1 == n_links);
			pending_links  = {pending_links, lw};
		end
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? COORD_MAX : 0;
			// tight cluster so that equal distances turn up often
			1: return $urandom_range(0, 15);
			default: return $urandom_range(0, COORD_MAX);
		endcase
	endfunction

	task automatic send_cmd(input logic mode, input int x, input int y);
		cmd_word_t w;
		w.mode    = mode;
		w.point_x = FIELD_COORD_W'(x);
		w.point_y = FIELD_COORD_W'(y);
		while ($urandom_range(0, 99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		do @(posedge clk); while (cmd_stall);
		predict_links(w);
	endtask

	// Hold the command side until every outstanding link word has arrived
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_links.size() != 0);
	endtask

	task automatic test_empty_node_table();
		send_cmd(MODE_ENDPOINT, 0, 0);
		send_cmd(MODE_ENDPOINT, COORD_MAX, COORD_MAX);
		send_cmd(MODE_ENDPOINT, COORD_MAX, 0);
		send_cmd(MODE_ENDPOINT, 0, COORD_MAX);
		wait_drained();
	endtask

	task automatic test_ties_and_extremes();
		send_cmd(MODE_NODE, 100, 100);
		send_cmd(MODE_NODE, 100, 100);
		send_cmd(MODE_NODE, 120, 100);
		send_cmd(MODE_NODE, 80, 100);
		send_cmd(MODE_NODE, 1000, 1000);
		send_cmd(MODE_NODE, 1000, 1010);
		send_cmd(MODE_NODE, 0, 0);
		send_cmd(MODE_NODE, COORD_MAX, COORD_MAX);
		send_cmd(MODE_ENDPOINT, 110, 100);
		send_cmd(MODE_ENDPOINT, 90, 100);
		send_cmd(MODE_ENDPOINT, 1000, 1005);
		send_cmd(MODE_ENDPOINT, COORD_MAX, COORD_MAX - 1);
		send_cmd(MODE_ENDPOINT, 1, 0);
		send_cmd(MODE_ENDPOINT, 1365, 682);
		wait_drained();
	endtask

	task automatic test_random_words(input int snd_pct, input int rcv_pct, input int n_words);
		cmd_idle_pct  = snd_pct;
		link_idle_pct = rcv_pct;
		repeat (n_words)
			send_cmd($urandom_range(0, 1) ? MODE_ENDPOINT : MODE_NODE, rand_coord(), rand_coord());
		wait_drained();
	endtask

	task automatic test_full_tables();
		while (node_cnt < MAX_NODES)
			send_cmd(MODE_NODE, rand_coord(), rand_coord());
		// these appends are dropped
		repeat (3)
			send_cmd(MODE_NODE, rand_coord(), rand_coord());
		while (end_cnt < MAX_ENDPOINTS)
			send_cmd(MODE_ENDPOINT, rand_coord(), rand_coord());
		repeat (3)
			send_cmd(MODE_ENDPOINT, rand_coord(), rand_coord());
		wait_drained();
	endtask

	// Receive side: random stall and in-order comparison of each link word
	always @(posedge clk) begin
		link_word_t want;
		if (link_valid && !link_stall) begin
			if (pending_links.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected link word: link %0d", link.link_number);
			end else begin
				want = pending_links.pop_front();
				if (link !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("link word mismatch: exp link=%0d n=%0d/%0d (%0d,%0d)-(%0d,%0d) e=%b l=%b",
							want.link_number, want.node_first, want.node_second, want.first_x,
							want.first_y, want.second_x, want.second_y, want.no_nodes,
							want.last_link);
						$display("                    got link=%0d n=%0d/%0d (%0d,%0d)-(%0d,%0d) e=%b l=%b",
							link.link_number, link.node_first, link.node_second, link.first_x,
							link.first_y, link.second_x, link.second_y, link.no_nodes,
							link.last_link);
					end
				end
			end
		end
		link_stall <= arst_n && ($urandom_range(0, 99) < link_idle_pct);
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (link_valid && !link_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("nearest_node_link_builder_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);
		test_empty_node_table();
		test_ties_and_extremes();
		test_random_words(34, 77, 40);
		test_random_words(77, 34, 40);
		test_random_words(0, 0, 38);
		test_full_tables();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_links.size() == 0)
			$display("nearest_node_link_builder_tb: PASS");
		else
			$display("nearest_node_link_builder_tb: FAIL");
		$finish;
	end

endmodule
